[rtl/rhls_pkg.sv]
`timescale 1ns / 1ps

package rhls_pkg;

  // One restoring-division step per cell; 16 quotient bits per divider.
  localparam int NUM_STEPS = 16;

  // Hue scale in 1/64 degree.
  localparam int HUE_SIXTH = 3840;
  localparam int HUE_TURN  = 23040;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Word handed from cell to cell. Each divider keeps a partial remainder
  // and a shift word that loses dividend bits at the top and gains
  // quotient bits at the bottom.
  typedef struct packed {
    logic [7:0]  sat_den;
    logic [7:0]  sat_rem;
    logic [15:0] sat_nq;
    logic [7:0]  hue_den;
    logic [7:0]  hue_rem;
    logic [15:0] hue_nq;
    logic        hue_neg;
    sector_t     sector;
    logic [15:0] lightness;
    logic        achromatic;
  } div_word_t;

endpackage

[rtl/rhls_if.sv]
`timescale 1ns / 1ps

interface rhls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhls_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [15:0] lightness;
  logic [15:0] saturation;
  logic        achromatic;

  modport source (output valid, output hue, output lightness, output saturation,
                  output achromatic, input ready);
  modport sink   (input valid, input hue, input lightness, input saturation,
                  input achromatic, output ready);
endinterface

[rtl/rhls_prep.sv]
`timescale 1ns / 1ps

module rhls_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  output logic                down_valid,
  input  logic                down_ready,
  output rhls_pkg::div_word_t down_word
);
  import rhls_pkg::*;

  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [8:0]  sum;
  logic [8:0]  den_wide;
  logic [7:0]  diff;
  logic [7:0]  hue_a;
  logic [7:0]  hue_b;
  logic        hue_neg;
  logic [7:0]  hue_mag;
  logic [19:0] hue_num;
  logic [23:0] sat_num;
  logic [16:0] light_wide;
  sector_t     sector;
  div_word_t   word_next;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
  end

  always_comb begin
    if (red == mx) begin
      sector = SECT_RED;
    end else if (green == mx) begin
      sector = SECT_GREEN;
    end else begin
      sector = SECT_BLUE;
    end
  end

  always_comb begin
    case (sector)
      SECT_RED: begin
        hue_a = green;
        hue_b = blue;
      end
      SECT_GREEN: begin
        hue_a = blue;
        hue_b = red;
      end
      default: begin
        hue_a = red;
        hue_b = green;
      end
    endcase
  end

  assign hue_neg  = hue_a < hue_b;
  assign hue_mag  = hue_neg ? (hue_b - hue_a) : (hue_a - hue_b);
  // 3840 * mag = 4096 * mag - 256 * mag
  assign hue_num  = {hue_mag, 12'b0} - {4'b0, hue_mag, 8'b0};

  assign sum      = {1'b0, mx} + {1'b0, mn};
  assign diff     = mx - mn;
  assign den_wide = sum[8] ? (9'd510 - sum) : sum;
  // 65535 * diff
  assign sat_num  = {diff, 16'b0} - {16'b0, diff};
  // 65535 * sum / 510 = 257 * sum / 2
  assign light_wide = {sum, 8'b0} + {8'b0, sum};

  always_comb begin
    word_next.sat_den    = den_wide[7:0];
    word_next.sat_rem    = sat_num[23:16];
    word_next.sat_nq     = sat_num[15:0];
    word_next.hue_den    = diff;
    word_next.hue_rem    = {4'b0, hue_num[19:16]};
    word_next.hue_nq     = hue_num[15:0];
    word_next.hue_neg    = hue_neg;
    word_next.sector     = sector;
    word_next.lightness  = light_wide[16:1];
    word_next.achromatic = (diff == 8'd0);
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      down_word <= word_next;
    end
  end

endmodule

[rtl/rhls_cell.sv]
`timescale 1ns / 1ps

module rhls_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  rhls_pkg::div_word_t up_word,
  output logic                down_valid,
  input  logic                down_ready,
  output rhls_pkg::div_word_t down_word
);
  import rhls_pkg::*;

  logic [8:0] sat_trial;
  logic [8:0] hue_trial;
  logic       sat_q;
  logic       hue_q;
  div_word_t  word_next;

  // Restoring step: bring down the next dividend bit, subtract if it fits.
  assign sat_trial = {up_word.sat_rem, up_word.sat_nq[15]};
  assign hue_trial = {up_word.hue_rem, up_word.hue_nq[15]};
  assign sat_q     = sat_trial >= {1'b0, up_word.sat_den};
  assign hue_q     = hue_trial >= {1'b0, up_word.hue_den};

  always_comb begin
    word_next         = up_word;
    word_next.sat_rem = sat_q ? 8'(sat_trial - {1'b0, up_word.sat_den}) : sat_trial[7:0];
    word_next.sat_nq  = {up_word.sat_nq[14:0], sat_q};
    word_next.hue_rem = hue_q ? 8'(hue_trial - {1'b0, up_word.hue_den}) : hue_trial[7:0];
    word_next.hue_nq  = {up_word.hue_nq[14:0], hue_q};
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      down_word <= word_next;
    end
  end

endmodule

[rtl/rhls_post.sv]
`timescale 1ns / 1ps

module rhls_post (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  rhls_pkg::div_word_t up_word,
  output logic                down_valid,
  input  logic                down_ready,
  output logic [14:0]         hue,
  output logic [15:0]         lightness,
  output logic [15:0]         saturation,
  output logic                achromatic
);
  import rhls_pkg::*;

  logic [12:0] hue_mag;
  logic [15:0] hue_base;
  logic [15:0] hue_raw;
  logic [15:0] hue_wrap;

  // Floor toward minus infinity: a negative quotient with a remainder
  // grows by one in magnitude.
  assign hue_mag = {1'b0, up_word.hue_nq[11:0]}
                 + {12'b0, up_word.hue_neg && (up_word.hue_rem != 8'd0)};

  always_comb begin
    case (up_word.sector)
      SECT_RED:   hue_base = 16'd0;
      SECT_GREEN: hue_base = 16'(2 * HUE_SIXTH);
      default:    hue_base = 16'(4 * HUE_SIXTH);
    endcase
  end

  assign hue_raw  = up_word.hue_neg ? (hue_base - {3'b0, hue_mag})
                                    : (hue_base + {3'b0, hue_mag});
  assign hue_wrap = hue_raw[15] ? (hue_raw + 16'(HUE_TURN)) : hue_raw;

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      hue        <= up_word.achromatic ? 15'd0 : hue_wrap[14:0];
      lightness  <= up_word.lightness;
      saturation <= up_word.achromatic ? 16'd0 : up_word.sat_nq;
      achromatic <= up_word.achromatic;
    end
  end

endmodule

[rtl/rgb_to_hls_converter.sv]
`timescale 1ns / 1ps

// RGB to HLS converter for 8-bit pixels.
// Channels: pixel (sink) takes red/green/blue; result (source) gives hue in
// 1/64 degree (0..23039), lightness and saturation as 16-bit fractions
// (65535 = 1.0) and an achromatic flag. A word moves on valid && ready.
// Structure: one prep stage (max/min, numerators, lightness), a row of 16
// identical division cells, then one output stage (hue floor and wrap).
// Each cell retires one quotient bit of both the saturation and the hue
// division and hands its word to the next cell.
// Pipeline: 18 register stages; a pixel's word passes through the prep
// register, each cell register in turn and then the output register.
// Throughput: one pixel per cycle unless result stalls; pixels are independent.
// Each stage holds its word while the next one is full and stalled, so a
// stall at result backs up stage by stage; empty stages still take words,
// so pixel.ready stays high until every stage is occupied.
// Reset (rst, synchronous) empties every stage; no word is in flight after.
module rgb_to_hls_converter (
  input logic       clk,
  input logic       rst,
  rhls_in_if.sink   pixel,
  rhls_out_if.source result
);
  import rhls_pkg::*;

  // Handshake and word at each boundary of the cell row.
  logic      chain_valid [NUM_STEPS+1];
  logic      chain_ready [NUM_STEPS+1];
  div_word_t chain_word  [NUM_STEPS+1];

  rhls_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (pixel.valid),
    .up_ready   (pixel.ready),
    .red        (pixel.red),
    .green      (pixel.green),
    .blue       (pixel.blue),
    .down_valid (chain_valid[0]),
    .down_ready (chain_ready[0]),
    .down_word  (chain_word[0])
  );

  // Division row: cell k produces quotient bit 15-k of both dividers.
  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_cell
    rhls_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (chain_valid[k]),
      .up_ready   (chain_ready[k]),
      .up_word    (chain_word[k]),
      .down_valid (chain_valid[k+1]),
      .down_ready (chain_ready[k+1]),
      .down_word  (chain_word[k+1])
    );
  end

  // Output register: hue sign fix, wrap into one turn, achromatic override.
  rhls_post u_post (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (chain_valid[NUM_STEPS]),
    .up_ready   (chain_ready[NUM_STEPS]),
    .up_word    (chain_word[NUM_STEPS]),
    .down_valid (result.valid),
    .down_ready (result.ready),
    .hue        (result.hue),
    .lightness  (result.lightness),
    .saturation (result.saturation),
    .achromatic (result.achromatic)
  );

`ifndef ASSERT_OFF
  // Achromatic words carry no hue and no saturation.
  a_achro_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.achromatic |-> result.hue == 15'd0 && result.saturation == 16'd0)
    else $error("achromatic result with nonzero hue or saturation");

  // Hue always wrapped into one turn.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.hue < 15'(HUE_TURN))
    else $error("hue outside one turn");

  // A chromatic pixel has diff >= 1 and den <= 255, so saturation >= 257.
  a_sat_floor: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.achromatic |-> result.saturation >= 16'd257)
    else $error("chromatic result with saturation below 257");

  // A chromatic pixel has 1 <= max+min <= 509: lightness never at an end.
  a_light_open: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.achromatic |->
      result.lightness != 16'd0 && result.lightness != 16'hFFFF)
    else $error("chromatic result with lightness at an end of the range");

  // The first stage takes a word whenever it is empty.
  a_prep_take: assert property (@(posedge clk) disable iff (rst)
    !chain_valid[0] |-> pixel.ready)
    else $error("pixel stalled while the first stage is empty");
`endif

endmodule
